/* hw/rtl/maze_wall_union_find_core_assert.svh */
// Assertion helpers shared by the union-find core.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef MAZE_WALL_UNION_FIND_CORE_ASSERT_SVH
`define MAZE_WALL_UNION_FIND_CORE_ASSERT_SVH

// same-cycle implication
`define MWUF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MWUF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/mwuf_pkg.sv */
package mwuf_pkg;

	localparam int WallW = 13;
	localparam int SideW = 7;
	localparam int CountW = 13;
	localparam int WeightW = 13;

	typedef struct packed {
		logic [WallW-1:0] wall_number;
		logic             first_of_maze;
	} wall_item_t;

	typedef struct packed {
		logic              wall_removed;
		logic [SideW-1:0]  wall_row;
		logic [SideW-1:0]  wall_col;
		logic [CountW-1:0] sets_left;
		logic              maze_complete;
	} result_item_t;

	typedef struct packed {
		logic             start;
		logic [WallW-1:0] dividend;
		logic [SideW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [WallW-1:0] quotient;
		logic [SideW-1:0] remainder;
	} div_rsp_t;

endpackage

/* hw/rtl/mwuf_div.sv */
module mwuf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  mwuf_pkg::div_req_t req,
	output mwuf_pkg::div_rsp_t rsp
);
	import mwuf_pkg::*;

	localparam int CntW = $clog2(WallW + 1);

	logic             busy_q;
	logic [CntW-1:0]  cnt_q;
	logic [WallW-1:0] quo_q;
	logic [SideW:0]   rem_q;
	logic [SideW-1:0] dvs_q;
	logic             done_q;
	logic [SideW:0]   rem_sh;
	logic             fits;

	// restoring division, one quotient bit per cycle, MSB first
	assign rem_sh = {rem_q[SideW-1:0], quo_q[WallW-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(WallW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[WallW-2:0], fits};
			rem_q <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q[SideW-1:0];

endmodule

/* hw/rtl/maze_wall_union_find_core.sv */
// Randomized Kruskal maze core: one candidate wall per wall transfer, one result
// transfer per wall. After reset, and whenever a wall arrives with first_of_maze
// set, a clearing pass writes all MAX_SIDE*MAX_SIDE cells back to singleton sets
// while wall_stall stays high; maze_side writes are still taken then. A joining
// wall goes from its transfer through decode, range check, the bit-serial divider
// that splits the wall number into row and column, the address step, four tree
// walks (find and compress for each cell) that follow one parent pointer per
// hop, the two weight reads and the join, to its result; it then returns to idle
// before the next wall can be taken. The walks are bound by the one read port of
// the parent memory. A wall whose two cells already share a root skips the weight
// reads and the join. Out-of-range walls, and all walls once one set remains,
// skip the divider and walks. A finished result sits in an output register, so
// the next wall can be taken while it waits.
module maze_wall_union_find_core #(
	parameter int MAX_SIDE = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   maze_side_we,
	input  logic [6:0]             maze_side_wdata,
	input  logic                   wall_valid,
	output logic                   wall_stall,
	input  mwuf_pkg::wall_item_t   wall_data,
	output logic                   result_valid,
	input  logic                   result_stall,
	output mwuf_pkg::result_item_t result_data
);
	import mwuf_pkg::*;

	`include "maze_wall_union_find_core_assert.svh"

	localparam int Depth = MAX_SIDE * MAX_SIDE;
	localparam int CellW = $clog2(Depth);
	localparam logic [SideW-1:0] SideMax = SideW'(MAX_SIDE);
	localparam logic [SideW-1:0] SideMin = SideW'(2);
	localparam logic [SideW-1:0] SideReset = SideW'(24);
	localparam logic [CountW-1:0] SetsReset = CountW'(576);

	typedef enum logic [13:0] {
		S_IDLE   = 14'h0001,
		S_CLEAR  = 14'h0002,
		S_DEC    = 14'h0004,
		S_CHK    = 14'h0008,
		S_DIV    = 14'h0010,
		S_ADDR   = 14'h0020,
		S_F_RD   = 14'h0040,
		S_F_WALK = 14'h0080,
		S_C_RD   = 14'h0100,
		S_C_WALK = 14'h0200,
		S_WT_A   = 14'h0400,
		S_WT_B   = 14'h0800,
		S_JOIN   = 14'h1000,
		S_DONE   = 14'h2000
	} state_t;

	state_t state_q;

	// config and per-wall registers
	logic [SideW-1:0]  side_cfg_q;
	logic [SideW-1:0]  side_q;
	logic [CountW-1:0] half_q;
	logic [CountW-1:0] sets_q;
	wall_item_t        wall_q;
	logic              horiz_q;
	logic              second_q;
	logic              removed_q;
	logic              reinit_q;
	logic [CellW-1:0]  clr_q;
	logic [CellW-1:0]  a_q, b_q, cur_q, root_q, ra_q, rb_q;
	logic [SideW-1:0]  row_q, col_q;
	logic [WeightW-1:0] wa_q;
	logic              result_valid_q;
	result_item_t      result_q;

	// memories
	logic [CellW-1:0]   parent_mem [Depth];
	logic [WeightW-1:0] weight_mem [Depth];
	logic [CellW-1:0]   p_rd_q;
	logic [WeightW-1:0] w_rd_q;
	logic               p_we, w_we;
	logic [CellW-1:0]   p_addr, p_waddr, p_wdata, w_addr, w_waddr;
	logic [WeightW-1:0] w_wdata;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [SideW-1:0]     side_eff;
	logic [CountW-1:0]    side_ext;
	logic [2*SideW-1:0]   cell_full;
	logic [2*SideW-1:0]   b_full;
	logic [SideW-1:0]     r_div, c_div;
	logic [CellW-1:0]     start_cell;
	logic [WeightW-1:0]   w_sum;
	logic                 in_range, horiz, live;
	logic                 out_free;

	mwuf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// clamp the side register to what the grid holds
	always_comb begin
		side_eff = side_cfg_q;
		if (side_cfg_q < SideMin)
			side_eff = SideMin;
		else if (side_cfg_q > SideMax)
			side_eff = SideMax;
	end

	// widened so side*side = 4096 does not wrap
	assign side_ext = CountW'(side_eff);

	assign in_range = {1'b0, wall_q.wall_number} < {half_q, 1'b0};
	assign horiz    = wall_q.wall_number < half_q;
	assign live     = (sets_q > CountW'(1)) && in_range;

	assign div_req.start    = (state_q == S_CHK) && live;
	assign div_req.dividend = horiz ? wall_q.wall_number : (wall_q.wall_number - half_q);
	assign div_req.divisor  = horiz ? (side_q - 1'b1) : side_q;

	assign r_div     = div_rsp.quotient[SideW-1:0];
	assign c_div     = div_rsp.remainder;
	assign cell_full = r_div * side_q + {{SideW{1'b0}}, c_div};
	assign b_full    = cell_full + (horiz_q ? {{(2*SideW-1){1'b0}}, 1'b1}
	                                        : {{SideW{1'b0}}, side_q});

	assign start_cell = second_q ? b_q : a_q;
	assign w_sum      = wa_q + w_rd_q;
	assign out_free   = !result_valid_q || !result_stall;

	// memory port control
	always_comb begin
		p_addr  = cur_q;
		p_we    = 1'b0;
		p_waddr = cur_q;
		p_wdata = root_q;
		w_addr  = ra_q;
		w_we    = 1'b0;
		w_waddr = ra_q;
		w_wdata = w_sum;
		unique case (state_q)
			S_CLEAR: begin
				p_we    = 1'b1;
				p_waddr = clr_q;
				p_wdata = clr_q;
				w_we    = 1'b1;
				w_waddr = clr_q;
				w_wdata = WeightW'(1);
			end
			S_F_RD, S_C_RD: p_addr = start_cell;
			S_F_WALK: p_addr = p_rd_q;
			S_C_WALK: begin
				// compress: point every node on the path straight at the root
				p_addr = p_rd_q;
				p_we   = p_rd_q != root_q;
			end
			S_WT_A: w_addr = ra_q;
			S_WT_B: w_addr = rb_q;
			S_JOIN: begin
				// lighter set goes under the heavier; first root wins a tie
				p_we = 1'b1;
				w_we = 1'b1;
				if (wa_q < w_rd_q) begin
					p_waddr = ra_q;
					p_wdata = rb_q;
					w_waddr = rb_q;
				end else begin
					p_waddr = rb_q;
					p_wdata = ra_q;
					w_waddr = ra_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (p_we)
			parent_mem[p_waddr] <= p_wdata;
		p_rd_q <= parent_mem[p_addr];
	end

	always_ff @(posedge clk) begin
		if (w_we)
			weight_mem[w_waddr] <= w_wdata;
		w_rd_q <= weight_mem[w_addr];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			side_cfg_q     <= SideReset;
			sets_q         <= SetsReset;
			clr_q          <= '0;
			reinit_q       <= 1'b0;
			second_q       <= 1'b0;
			removed_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (maze_side_we)
				side_cfg_q <= maze_side_wdata;
			if (state_q == S_DONE && out_free)
				result_valid_q <= 1'b1;
			else if (result_valid_q && !result_stall)
				result_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (wall_valid) begin
						removed_q <= 1'b0;
						second_q  <= 1'b0;
						clr_q     <= '0;
						reinit_q  <= wall_data.first_of_maze;
						state_q   <= wall_data.first_of_maze ? S_CLEAR : S_DEC;
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CellW'(Depth - 1)) begin
						if (reinit_q)
							sets_q <= side_ext * side_ext;
						state_q <= reinit_q ? S_DEC : S_IDLE;
					end
				end
				S_DEC:    state_q <= S_CHK;
				S_CHK:    state_q <= live ? S_DIV : S_DONE;
				S_DIV:    if (div_rsp.done) state_q <= S_ADDR;
				S_ADDR:   state_q <= S_F_RD;
				S_F_RD:   state_q <= S_F_WALK;
				S_F_WALK: if (p_rd_q == cur_q) state_q <= S_C_RD;
				S_C_RD:   state_q <= S_C_WALK;
				S_C_WALK: begin
					if (p_rd_q == root_q) begin
						if (!second_q) begin
							second_q <= 1'b1;
							state_q  <= S_F_RD;
						end else begin
							state_q <= (root_q == ra_q) ? S_DONE : S_WT_A;
						end
					end
				end
				S_WT_A:   state_q <= S_WT_B;
				S_WT_B:   state_q <= S_JOIN;
				S_JOIN: begin
					sets_q    <= sets_q - 1'b1;
					removed_q <= 1'b1;
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && wall_valid)
			wall_q <= wall_data;
		if (state_q == S_DEC) begin
			side_q <= side_eff;
			half_q <= side_ext * (side_ext - CountW'(1));
		end
		if (state_q == S_CHK)
			horiz_q <= horiz;
		if (state_q == S_ADDR) begin
			a_q <= CellW'(cell_full);
			b_q <= CellW'(b_full);
			row_q <= {r_div[SideW-2:0], 1'b0} + (horiz_q ? SideW'(1) : SideW'(2));
			col_q <= {c_div[SideW-2:0], 1'b0} + (horiz_q ? SideW'(2) : SideW'(1));
		end
		if (state_q == S_F_RD || state_q == S_C_RD)
			cur_q <= start_cell;
		if (state_q == S_F_WALK) begin
			if (p_rd_q == cur_q)
				root_q <= cur_q;
			else
				cur_q <= p_rd_q;
		end
		if (state_q == S_C_WALK && p_rd_q != root_q)
			cur_q <= p_rd_q;
		if (state_q == S_C_WALK && p_rd_q == root_q) begin
			if (!second_q)
				ra_q <= root_q;
			else
				rb_q <= root_q;
		end
		if (state_q == S_WT_B)
			wa_q <= w_rd_q;
		if (state_q == S_DONE && out_free) begin
			result_q.wall_removed  <= removed_q;
			result_q.wall_row      <= removed_q ? row_q : '0;
			result_q.wall_col      <= removed_q ? col_q : '0;
			result_q.sets_left     <= sets_q;
			result_q.maze_complete <= sets_q <= CountW'(1);
		end
	end

	assign wall_stall   = state_q != S_IDLE;
	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	`MWUF_ASSERT_NOW(a_join_distinct, state_q == S_JOIN, ra_q != rb_q,
		"join of two cells already in one set")
	`MWUF_ASSERT_NEXT(a_join_count, state_q == S_JOIN, sets_q == $past(sets_q) - 1'b1,
		"set count did not drop on a join")
	`MWUF_ASSERT_NOW(a_compress_root, state_q == S_C_WALK && p_rd_q != root_q,
		cur_q != root_q, "compression would rewrite the root")
	`MWUF_ASSERT_NOW(a_sets_floor, state_q == S_JOIN, sets_q > CountW'(1),
		"join with one set left")

endmodule
